// File: rtl/core/mcpu_pkg.sv
// Package for the MOV/ADD minicomputer core.
// Holds widths, func/op codes, state and memory request types; no dependencies.
`default_nettype none
package mcpu_pkg;
   localparam int ADDR_BITS = 16;
   localparam int MEM_AW = ADDR_BITS - 1;
   localparam int MEM_WORDS = 1 << MEM_AW;

   typedef enum logic [1:0] {
      FUNC_EXEC = 2'd0,
      FUNC_MWR  = 2'd1,
      FUNC_MRD  = 2'd2,
      FUNC_RRD  = 2'd3
   } func_type;

   localparam logic [3:0] OP_MOV = 4'd1;
   localparam logic [3:0] OP_ADD = 4'd6;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_FETCH,   // wait for instruction word
      ST_DECODE,
      ST_SPEC,    // resolve operand spec
      ST_IDX,     // wait for index word
      ST_PTR,     // wait for pointer word
      ST_OPND,    // wait for operand word
      ST_WB,      // write result
      ST_MRD,     // wait for host memory read
      ST_DONE
   } state_type;

   typedef struct packed {
      logic             we;
      logic [MEM_AW-1:0] addr;
      logic [15:0]      wdata;
   } mem_req_type;

   function automatic logic [MEM_AW-1:0] word_idx(input logic [15:0] a);
      word_idx = a[ADDR_BITS-1:1];
   endfunction
endpackage
`default_nettype wire

// File: rtl/core/mcpu_mem.sv
// Word memory of the core: one port, synchronous (registered) read.
// Depends on mcpu_pkg.
`default_nettype none
module mcpu_mem (
   input  wire logic                clock,
   input  wire mcpu_pkg::mem_req_type req,
   input  wire logic                en,
   output logic [15:0]             rdata
);
   logic [15:0] mem [mcpu_pkg::MEM_WORDS];
   always_ff @(posedge clock) begin
      if (en) begin
         if (req.we) mem[req.addr] <= req.wdata;
         rdata <= mem[req.addr];
      end
   end
endmodule
`default_nettype wire

// File: rtl/core/minicpu_mov_add_core.sv
// Top level of the MOV/ADD minicomputer core: request sequencer and register file.
// Depends on mcpu_pkg and mcpu_mem.
//
//  channel | ports                                   | direction
//  req     | req_valid/ready, func, mem_address, ... | in
//  rsp     | rsp_valid/ready, read_data, ...         | out
//
// Memory write, register read and a step of a halted core pass the done state,
// memory read the read-wait state and done. An instruction passes fetch, decode
// and done, plus per operand: spec for a register; spec, operand for (Rn), (Rn)+,
// -(Rn); spec, pointer, operand for @(Rn)+, @-(Rn); spec, index, operand for X(Rn);
// spec, index, pointer, operand for @X(Rn); MOV/ADD add a write-back state.
// Reset is synchronous and clears registers, flags, halt and count; the
// memory has no reset. A request is taken only when the previous response
// has left; the response register holds while rsp_ready is low.
`default_nettype none
module minicpu_mov_add_core (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [1:0]  req_func,
   input  wire logic [15:0] req_mem_address,
   input  wire logic [15:0] req_write_data,
   input  wire logic [2:0]  req_reg_select,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [15:0]      rsp_read_data,
   output logic [15:0]      rsp_prog_counter,
   output logic [3:0]       rsp_cond_flags,
   output logic             rsp_is_halted,
   output logic [31:0]      rsp_executed_count
);
   mcpu_pkg::state_type state_ff, state_in;
   logic [15:0] regs_ff [8];
   logic [15:0] regs_in [8];
   logic [3:0]  flags_ff, flags_in;
   logic        halt_ff, halt_in;
   logic [31:0] cnt_ff, cnt_in;
   logic [15:0] ir_ff, ir_in;      // instruction word
   logic        side_ff, side_in;  // 0 source, 1 destination
   logic [15:0] sv_ff, sv_in;      // source value
   logic [15:0] ea_ff, ea_in;      // effective address
   logic        dreg_ff, dreg_in;  // destination is a register
   logic        valid_ff, valid_in;
   logic [15:0] rd_ff, rd_in;
   logic [15:0] mrd;
   logic        mem_en;
   mcpu_pkg::mem_req_type mreq;

   mcpu_mem u_mem (.clock(clock), .req(mreq), .en(mem_en), .rdata(mrd));

   logic [5:0]  spec;
   logic [2:0]  mode, rn;
   logic [15:0] sum;
   logic [16:0] add17;
   logic [15:0] opv;

   assign spec = side_ff ? ir_ff[5:0] : ir_ff[11:6];
   assign mode = spec[5:3];
   assign rn   = spec[2:0];

   // next-state logic of the sequencer: requests, operand resolution and write-back
   always_comb begin
      state_in = state_ff;
      for (int i = 0; i < 8; i++) regs_in[i] = regs_ff[i];
      flags_in = flags_ff; halt_in = halt_ff; cnt_in = cnt_ff;
      ir_in = ir_ff; side_in = side_ff; sv_in = sv_ff; ea_in = ea_ff;
      dreg_in = dreg_ff; valid_in = valid_ff; rd_in = rd_ff;
      mem_en = 1'b0;
      mreq = '{we: 1'b0, addr: mcpu_pkg::word_idx(16'd0), wdata: 16'd0};
      req_ready = (state_ff == mcpu_pkg::ST_IDLE) && !valid_ff;
      opv = 16'd0; add17 = 17'd0; sum = 16'd0;
      if (valid_ff && rsp_ready) valid_in = 1'b0;
      unique case (state_ff)
         mcpu_pkg::ST_IDLE: begin
            if (req_valid && req_ready) begin
               rd_in = 16'd0;
               unique case (mcpu_pkg::func_type'(req_func))
                  mcpu_pkg::FUNC_EXEC: begin
                     if (halt_ff) state_in = mcpu_pkg::ST_DONE;
                     else begin
                        mem_en = 1'b1;
                        mreq.addr = mcpu_pkg::word_idx(regs_ff[7]);
                        regs_in[7] = regs_ff[7] + 16'd2;
                        state_in = mcpu_pkg::ST_FETCH;
                     end
                  end
                  mcpu_pkg::FUNC_MWR: begin
                     mem_en = 1'b1;
                     mreq = '{we: 1'b1, addr: mcpu_pkg::word_idx(req_mem_address),
                              wdata: req_write_data};
                     state_in = mcpu_pkg::ST_DONE;
                  end
                  mcpu_pkg::FUNC_MRD: begin
                     mem_en = 1'b1;
                     mreq.addr = mcpu_pkg::word_idx(req_mem_address);
                     state_in = mcpu_pkg::ST_MRD;
                  end
                  mcpu_pkg::FUNC_RRD: begin
                     rd_in = regs_ff[req_reg_select];
                     state_in = mcpu_pkg::ST_DONE;
                  end
               endcase
            end
         end
         mcpu_pkg::ST_MRD: begin
            rd_in = mrd;
            state_in = mcpu_pkg::ST_DONE;
         end
         mcpu_pkg::ST_FETCH: begin
            ir_in = mrd;
            state_in = mcpu_pkg::ST_DECODE;
         end
         mcpu_pkg::ST_DECODE: begin
            cnt_in = cnt_ff + 32'd1;
            side_in = 1'b0;
            if (ir_ff[15:12] == mcpu_pkg::OP_MOV || ir_ff[15:12] == mcpu_pkg::OP_ADD)
               state_in = mcpu_pkg::ST_SPEC;
            else begin
               if (ir_ff == 16'd0) halt_in = 1'b1;
               state_in = mcpu_pkg::ST_DONE;
            end
         end
         mcpu_pkg::ST_SPEC: begin
            unique case (mode)
               3'd0: begin
                  // register operand
                  opv = regs_ff[rn];
                  if (!side_ff) begin
                     sv_in = opv; side_in = 1'b1;
                  end else begin
                     dreg_in = 1'b1; ea_in = {13'd0, rn};
                     state_in = mcpu_pkg::ST_WB;
                  end
               end
               3'd1, 3'd2, 3'd4: begin
                  if (mode == 3'd4) begin
                     ea_in = regs_ff[rn] - 16'd2; regs_in[rn] = ea_in;
                  end else begin
                     ea_in = regs_ff[rn];
                     if (mode == 3'd2) regs_in[rn] = regs_ff[rn] + 16'd2;
                  end
                  dreg_in = 1'b0;
                  mem_en = 1'b1; mreq.addr = mcpu_pkg::word_idx(ea_in);
                  state_in = mcpu_pkg::ST_OPND;
               end
               3'd3, 3'd5: begin
                  if (mode == 3'd5) begin
                     regs_in[rn] = regs_ff[rn] - 16'd2;
                     mreq.addr = mcpu_pkg::word_idx(regs_in[rn]);
                  end else begin
                     mreq.addr = mcpu_pkg::word_idx(regs_ff[rn]);
                     regs_in[rn] = regs_ff[rn] + 16'd2;
                  end
                  mem_en = 1'b1;
                  state_in = mcpu_pkg::ST_PTR;
               end
               default: begin
                  // index word at PC
                  mem_en = 1'b1; mreq.addr = mcpu_pkg::word_idx(regs_ff[7]);
                  regs_in[7] = regs_ff[7] + 16'd2;
                  state_in = mcpu_pkg::ST_IDX;
               end
            endcase
         end
         mcpu_pkg::ST_IDX: begin
            ea_in = mrd + regs_ff[rn];
            mem_en = 1'b1; mreq.addr = mcpu_pkg::word_idx(ea_in);
            dreg_in = 1'b0;
            state_in = (mode == 3'd7) ? mcpu_pkg::ST_PTR : mcpu_pkg::ST_OPND;
         end
         mcpu_pkg::ST_PTR: begin
            ea_in = mrd;
            dreg_in = 1'b0;
            mem_en = 1'b1; mreq.addr = mcpu_pkg::word_idx(mrd);
            state_in = mcpu_pkg::ST_OPND;
         end
         mcpu_pkg::ST_OPND: begin
            if (!side_ff) begin
               sv_in = mrd; side_in = 1'b1;
               state_in = mcpu_pkg::ST_SPEC;
            end else begin
               // MOV ignores the old word; ADD uses it
               sv_in = sv_ff;
               rd_in = mrd;  // hold destination word
               state_in = mcpu_pkg::ST_WB;
            end
         end
         mcpu_pkg::ST_WB: begin
            opv = dreg_ff ? regs_ff[ea_ff[2:0]] : rd_ff;
            add17 = {1'b0, sv_ff} + {1'b0, opv};
            if (ir_ff[15:12] == mcpu_pkg::OP_ADD) begin
               sum = add17[15:0];
               flags_in = {sum[15], sum == 16'd0,
                           (~(sv_ff[15] ^ opv[15])) & (sv_ff[15] ^ sum[15]), add17[16]};
            end else begin
               sum = sv_ff;
               flags_in = {sum[15], sum == 16'd0, 1'b0, flags_ff[0]};
            end
            if (dreg_ff) regs_in[ea_ff[2:0]] = sum;
            else begin
               mem_en = 1'b1;
               mreq = '{we: 1'b1, addr: mcpu_pkg::word_idx(ea_ff), wdata: sum};
            end
            rd_in = 16'd0;
            state_in = mcpu_pkg::ST_DONE;
         end
         mcpu_pkg::ST_DONE: begin
            valid_in = 1'b1;
            state_in = mcpu_pkg::ST_IDLE;
         end
         default: state_in = mcpu_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mcpu_pkg::ST_IDLE;
         for (int i = 0; i < 8; i++) regs_ff[i] <= 16'd0;
         flags_ff <= 4'd0; halt_ff <= 1'b0; cnt_ff <= 32'd0;
         valid_ff <= 1'b0; side_ff <= 1'b0; dreg_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         for (int i = 0; i < 8; i++) regs_ff[i] <= regs_in[i];
         flags_ff <= flags_in; halt_ff <= halt_in; cnt_ff <= cnt_in;
         valid_ff <= valid_in; side_ff <= side_in; dreg_ff <= dreg_in;
      end
      ir_ff <= ir_in; sv_ff <= sv_in; ea_ff <= ea_in; rd_ff <= rd_in;
   end

   assign rsp_valid          = valid_ff;
   assign rsp_read_data      = rd_ff;
   assign rsp_prog_counter   = regs_ff[7];
   assign rsp_cond_flags     = flags_ff;
   assign rsp_is_halted      = halt_ff;
   assign rsp_executed_count = cnt_ff;

   a_halt_sticky: assert property (@(posedge clock) disable iff (reset)
      halt_ff |=> halt_ff) else $error("halt flag cleared");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      valid_ff && !rsp_ready |=> valid_ff && $stable(rd_ff)) else $error("response lost");
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> state_ff == mcpu_pkg::ST_IDLE && !valid_ff) else $error("busy accept");
endmodule
`default_nettype wire

// File: sim/minicpu_mov_add_core_tb.sv
// Testbench for the MOV/ADD minicomputer core: directed table, then random
// requests; every response is checked against a behavioral model of the core.
// Depends on mcpu_pkg and the core RTL.
`default_nettype none
module minicpu_mov_add_core_tb;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [1:0]  req_func;
   logic [15:0] req_mem_address;
   logic [15:0] req_write_data;
   logic [2:0]  req_reg_select;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [15:0] rsp_read_data;
   logic [15:0] rsp_prog_counter;
   logic [3:0]  rsp_cond_flags;
   logic        rsp_is_halted;
   logic [31:0] rsp_executed_count;

   minicpu_mov_add_core u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_func(req_func), .req_mem_address(req_mem_address),
      .req_write_data(req_write_data), .req_reg_select(req_reg_select),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_read_data(rsp_read_data), .rsp_prog_counter(rsp_prog_counter),
      .rsp_cond_flags(rsp_cond_flags), .rsp_is_halted(rsp_is_halted),
      .rsp_executed_count(rsp_executed_count)
   );

   // One response as seen on the rsp channel.
   typedef struct packed {
      logic [15:0] rdata;
      logic [15:0] pc;
      logic [3:0]  nzvc;
      logic        halted;
      logic [31:0] count;
   } core_status_type;

   // One directed row; chk_rdata set means read data is typed in.
   typedef struct {
      mcpu_pkg::func_type fn;
      logic [15:0] addr;
      logic [15:0] wdata;
      logic [2:0]  sel;
      logic        chk_rdata;
      logic [15:0] rdata;
   } row_type;

   // Operand location: a register or a memory byte address.
   typedef struct {
      logic        is_reg;
      logic [15:0] loc;
   } opnd_type;

   // Shadow copy of the core's architectural state.
   logic [15:0] shadow_regs [8];
   logic [3:0]  shadow_nzvc;
   logic        shadow_halt;
   logic [31:0] shadow_count;
   logic [15:0] shadow_mem [mcpu_pkg::MEM_WORDS];
   bit          mem_known [mcpu_pkg::MEM_WORDS];

   core_status_type status_queue[$];
   logic         rdata_typed[$];
   logic [15:0]  rdata_typed_val[$];
   int  n_errors = 0;
   bit  stim_done = 0;
   bit  quiet_phase = 0;   // stretch with no idling on either side
   int  hold_cycles = 0;   // receiver hold-off, counted down at the clock

   function automatic logic [mcpu_pkg::MEM_AW-1:0] widx(input logic [15:0] a);
      return a[mcpu_pkg::ADDR_BITS-1:1];
   endfunction

   function automatic logic [15:0] mread(input logic [15:0] a);
      return shadow_mem[widx(a)];
   endfunction

   function automatic logic [15:0] take_word();
      logic [15:0] w;
      w = mread(shadow_regs[7]);
      shadow_regs[7] = shadow_regs[7] + 16'd2;
      return w;
   endfunction

   function automatic opnd_type locate(input logic [5:0] spec);
      logic [2:0]  r;
      logic [15:0] a;
      opnd_type o;
      r = spec[2:0];
      o.is_reg = 1'b0;
      o.loc = 16'd0;
      a = 16'd0;
      case (spec[5:3])
         3'd0: begin
            o.is_reg = 1'b1;
            o.loc = {13'd0, r};
            return o;
         end
         3'd1: a = shadow_regs[r];
         3'd2: begin
            a = shadow_regs[r];
            shadow_regs[r] = shadow_regs[r] + 16'd2;
         end
         3'd3: begin
            a = mread(shadow_regs[r]);
            shadow_regs[r] = shadow_regs[r] + 16'd2;
         end
         3'd4: begin
            shadow_regs[r] = shadow_regs[r] - 16'd2;
            a = shadow_regs[r];
         end
         3'd5: begin
            shadow_regs[r] = shadow_regs[r] - 16'd2;
            a = mread(shadow_regs[r]);
         end
         3'd6: begin
            a = take_word();
            a = a + shadow_regs[r];
         end
         default: begin
            a = take_word();
            a = mread(a + shadow_regs[r]);
         end
      endcase
      o.loc = a;
      return o;
   endfunction

   function automatic logic [15:0] opnd_read(input opnd_type o);
      return o.is_reg ? shadow_regs[o.loc[2:0]] : mread(o.loc);
   endfunction

   function automatic void opnd_write(input opnd_type o, input logic [15:0] v);
      if (o.is_reg) shadow_regs[o.loc[2:0]] = v;
      else begin
         shadow_mem[widx(o.loc)] = v;
         mem_known[widx(o.loc)] = 1;
      end
   endfunction

   // Runs one instruction on the shadow state.
   function automatic void run_instruction();
      logic [15:0] w, sv, dv, res;
      logic [16:0] sum;
      opnd_type s, d;
      w = take_word();
      if (w[15:12] == mcpu_pkg::OP_MOV) begin
         s = locate(w[11:6]);
         sv = opnd_read(s);
         d = locate(w[5:0]);
         opnd_write(d, sv);
         shadow_nzvc[3] = sv[15];
         shadow_nzvc[2] = (sv == 16'd0);
         shadow_nzvc[1] = 1'b0;
      end else if (w[15:12] == mcpu_pkg::OP_ADD) begin
         s = locate(w[11:6]);
         sv = opnd_read(s);
         d = locate(w[5:0]);
         dv = opnd_read(d);
         sum = {1'b0, sv} + {1'b0, dv};
         res = sum[15:0];
         opnd_write(d, res);
         shadow_nzvc = {res[15], res == 16'd0, (sv[15] == dv[15]) && (res[15] != sv[15]),
                        sum[16]};
      end else if (w == 16'd0) begin
         shadow_halt = 1'b1;
      end
      shadow_count = shadow_count + 32'd1;
   endfunction

   // Applies one request to the shadow state, returns the expected response.
   function automatic core_status_type predict_status(input mcpu_pkg::func_type fn,
                                                      input logic [15:0] addr,
                                                      input logic [15:0] wdata,
                                                      input logic [2:0] sel);
      core_status_type st;
      st.rdata = 16'd0;
      case (fn)
         mcpu_pkg::FUNC_EXEC: if (!shadow_halt) run_instruction();
         mcpu_pkg::FUNC_MWR: begin
            shadow_mem[widx(addr)] = wdata;
            mem_known[widx(addr)] = 1;
         end
         mcpu_pkg::FUNC_MRD: st.rdata = mread(addr);
         default:  st.rdata = shadow_regs[sel];
      endcase
      st.pc = shadow_regs[7];
      st.nzvc = shadow_nzvc;
      st.halted = shadow_halt;
      st.count = shadow_count;
      return st;
   endfunction

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // Sends one request; waits until accepted, with random idling beforehand.
   // Valid stays high between back-to-back requests; it drops only while idling.
   task automatic send_request(input mcpu_pkg::func_type fn, input logic [15:0] addr,
                               input logic [15:0] wdata, input logic [2:0] sel,
                               input logic chk, input logic [15:0] typed);
      while (!quiet_phase && $urandom_range(99) < 12) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_func <= fn;
      req_mem_address <= addr;
      req_write_data <= wdata;
      req_reg_select <= sel;
      status_queue.push_back(predict_status(fn, addr, wdata, sel));
      rdata_typed.push_back(chk);
      rdata_typed_val.push_back(typed);
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_word(input logic [15:0] a, input logic [15:0] v);
      send_request(mcpu_pkg::FUNC_MWR, a, v, 3'($urandom), 1'b0, 16'd0);
   endtask

   task automatic execute_one();
      send_request(mcpu_pkg::FUNC_EXEC, 16'($urandom), 16'($urandom), 3'($urandom),
                   1'b0, 16'd0);
   endtask

   // Response checking at the rising edge.
   always @(posedge clock) begin
      core_status_type ex;
      logic chk;
      logic [15:0] tv;
      if (!reset && rsp_valid && rsp_ready) begin
         if (status_queue.size() == 0) begin
            $error("response with none expected");
            n_errors++;
         end else begin
            ex = status_queue.pop_front();
            chk = rdata_typed.pop_front();
            tv = rdata_typed_val.pop_front();
            if (chk && tv != ex.rdata) begin
               $error("read_data table: exp %h act %h", tv, ex.rdata);
               n_errors++;
            end
            if (rsp_read_data !== ex.rdata) begin
               $error("read_data: exp %h act %h", ex.rdata, rsp_read_data);
               n_errors++;
            end
            if (rsp_prog_counter !== ex.pc) begin
               $error("prog_counter: exp %h act %h", ex.pc, rsp_prog_counter);
               n_errors++;
            end
            if (rsp_cond_flags !== ex.nzvc) begin
               $error("cond_flags: exp %h act %h", ex.nzvc, rsp_cond_flags);
               n_errors++;
            end
            if (rsp_is_halted !== ex.halted) begin
               $error("is_halted: exp %b act %b", ex.halted, rsp_is_halted);
               n_errors++;
            end
            if (rsp_executed_count !== ex.count) begin
               $error("executed_count: exp %h act %h", ex.count, rsp_executed_count);
               n_errors++;
            end
         end
      end
   end

   // Receiver: random stalls, plus one long hold-off when hold_cycles is set.
   always @(negedge clock) begin
      if (hold_cycles > 0) begin
         rsp_ready <= 0;
         hold_cycles <= hold_cycles - 1;
      end else
         rsp_ready <= quiet_phase || ($urandom_range(99) >= 12);
   end

   row_type table_rows[$];

   initial begin
      int i, n;
      row_type r;
      reset = 1;
      req_valid = 0;
      req_func = mcpu_pkg::FUNC_EXEC;
      req_mem_address = 0;
      req_write_data = 0;
      req_reg_select = 0;
      rsp_ready = 0;
      foreach (shadow_regs[k]) shadow_regs[k] = 0;
      shadow_nzvc = 0;
      shadow_halt = 0;
      shadow_count = 0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // Directed table: registers after reset, address extremes, register and (PC)+ modes.
      table_rows = '{
         '{mcpu_pkg::FUNC_RRD, 16'h0000, 16'h0000, 3'd7, 1'b1, 16'h0000},
         '{mcpu_pkg::FUNC_RRD, 16'hFFFF, 16'hFFFF, 3'd0, 1'b1, 16'h0000},
         '{mcpu_pkg::FUNC_MWR, 16'hFFFF, 16'hFFFF, 3'd0, 1'b1, 16'h0000},
         '{mcpu_pkg::FUNC_MRD, 16'hFFFE, 16'h0000, 3'd0, 1'b1, 16'hFFFF},
         '{mcpu_pkg::FUNC_MWR, 16'h0001, 16'h8001, 3'd0, 1'b1, 16'h0000},
         '{mcpu_pkg::FUNC_MRD, 16'h0000, 16'h0000, 3'd0, 1'b1, 16'h8001},
         // program at 0: MOV (PC)+,R1 / #8001 ; ADD R1,R1 (overflow+carry)
         '{mcpu_pkg::FUNC_MWR, 16'h0000, {mcpu_pkg::OP_MOV, 6'o27, 6'o01}, 3'd0, 1'b1,
           16'h0000},
         '{mcpu_pkg::FUNC_MWR, 16'h0002, 16'h8001, 3'd0, 1'b1, 16'h0000},
         '{mcpu_pkg::FUNC_MWR, 16'h0004, {mcpu_pkg::OP_ADD, 6'o01, 6'o01}, 3'd0, 1'b1,
           16'h0000},
         '{mcpu_pkg::FUNC_MWR, 16'h0006, 16'h7FFF, 3'd0, 1'b1, 16'h0000},   // other opcode
         '{mcpu_pkg::FUNC_MWR, 16'h0008, {mcpu_pkg::OP_MOV, 6'o00, 6'o02}, 3'd0, 1'b1,
           16'h0000},                                                     // R0 zero
         '{mcpu_pkg::FUNC_MWR, 16'h000A, 16'h0000, 3'd0, 1'b1, 16'h0000},   // halt
         '{mcpu_pkg::FUNC_EXEC, 16'h0000, 16'h0000, 3'd0, 1'b0, 16'h0000},
         '{mcpu_pkg::FUNC_EXEC, 16'hFFFF, 16'hFFFF, 3'd7, 1'b0, 16'h0000},
         '{mcpu_pkg::FUNC_RRD, 16'h0000, 16'h0000, 3'd1, 1'b1, 16'h0002},
         '{mcpu_pkg::FUNC_EXEC, 16'h0000, 16'h0000, 3'd0, 1'b0, 16'h0000},
         '{mcpu_pkg::FUNC_EXEC, 16'h0000, 16'h0000, 3'd0, 1'b0, 16'h0000},
         '{mcpu_pkg::FUNC_EXEC, 16'h0000, 16'h0000, 3'd0, 1'b0, 16'h0000},
         '{mcpu_pkg::FUNC_EXEC, 16'h0000, 16'h0000, 3'd0, 1'b0, 16'h0000}, // halted
         '{mcpu_pkg::FUNC_RRD, 16'h0000, 16'h0000, 3'd7, 1'b1, 16'h000C},
         '{mcpu_pkg::FUNC_RRD, 16'h0000, 16'h0000, 3'd2, 1'b1, 16'h0000}
      };
      foreach (table_rows[k]) begin
         r = table_rows[k];
         send_request(r.fn, r.addr, r.wdata, r.sel, r.chk_rdata, r.rdata);
      end

      // Receiver holds off while requests keep coming.
      hold_cycles = 300;
      for (i = 0; i < 6; i++)
         send_request(mcpu_pkg::FUNC_RRD, 16'd0, 16'd0, 3'(i), 1'b0, 16'd0);

      // Random part: host writes, reads of written words, register reads and
      // execute requests. The directed program left the core halted, so an
      // execute request must leave the state unchanged.
      n = 0;
      while (n < 1850) begin
         quiet_phase = (n >= 600 && n < 800);
         case ($urandom_range(3))
            0: begin
               write_word(16'($urandom), 16'($urandom));
               n++;
            end
            1: begin
               logic [15:0] a;
               a = 16'($urandom);
               if (mem_known[widx(a)]) begin
                  send_request(mcpu_pkg::FUNC_MRD, a, 16'($urandom), 3'($urandom),
                               1'b0, 16'd0);
                  n++;
               end
            end
            2: begin
               send_request(mcpu_pkg::FUNC_RRD, 16'($urandom), 16'($urandom),
                            3'($urandom), 1'b0, 16'd0);
               n++;
            end
            default: begin
               execute_one();
               n++;
            end
         endcase
      end
      req_valid <= 1'b0;
      quiet_phase = 0;
      stim_done = 1;
   end

   initial begin
      wait (stim_done);
      while (status_queue.size() != 0) @(posedge clock);
      repeat (30) @(posedge clock);
      if (n_errors == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

   initial begin
      #20000000;
      $display("TEST FAILED");
      $finish;
   end
endmodule
`default_nettype wire
